FILE: design/rsdam_pkg.sv
// ----------------------------------------------------------------------------
// rsdam_pkg: shared constants and types for the pattern matcher
// Pattern size, special characters, register indexes and cell link structs.
// ----------------------------------------------------------------------------
package rsdam_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int NUM_POS           = MAX_PATTERN_BYTES + 1;   // bit len is the accept position
    localparam int LEN_W             = 6;
    localparam int WORD_W            = 64;
    localparam int CFG_IDX_W         = 3;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD0  = 3'd1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // static controls of one cell, derived from the pattern registers
    typedef struct packed {
        logic [7:0] pat_byte;
        logic       star;        // next pattern byte is '*'
        logic       in_range;    // position below length
        logic       in_mask;     // position not above length
        logic       at_len;      // accept position
        logic       end_anchor;  // final '$'
        logic       start;       // start position of the live set
        logic       is_zero;     // position 0, reset value of the live bit
    } t_cell_ctl;

    // signals common to every cell
    typedef struct packed {
        logic       at_start;
        logic       anch;
        logic [7:0] text_byte;
        logic       load;        // byte item taken
        logic       rearm;       // end item taken
    } t_bcast;

    // ripple link from one cell to the next
    typedef struct packed {
        logic adv;        // previous position consumed a byte and moves on
        logic cur_sk_a;   // skip over starred element, from the previous cell
        logic cur_sk_b;   // same, from two cells back
        logic nxt_sk_a;
        logic nxt_sk_b;
    } t_link;

    typedef struct packed {
        logic acc_cur;
        logic acc_nxt;
        logic end_hit;
    } t_cell_stat;

endpackage

FILE: design/rsdam_cell.sv
// ----------------------------------------------------------------------------
// rsdam_cell: one pattern position of the matcher row
// Holds the live bit, closes the set over starred elements and steps on a byte.
// ----------------------------------------------------------------------------
module rsdam_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rsdam_pkg::t_cell_ctl  i_ctl,
    input  rsdam_pkg::t_bcast     i_bc,
    input  rsdam_pkg::t_link      i_link,
    output rsdam_pkg::t_link      o_link,
    output rsdam_pkg::t_cell_stat o_stat
);
    import rsdam_pkg::*;

    logic r_live;
    logic pre;
    logic cur;
    logic byte_hit;
    logic step;
    logic nxt;

    always_comb begin
        pre      = (i_bc.at_start ? i_ctl.start : (r_live & i_ctl.in_mask))
                 | (~i_bc.anch & i_ctl.start);
        cur      = pre | i_link.cur_sk_b;
        byte_hit = (i_ctl.pat_byte == CH_DOT) | (i_ctl.pat_byte == i_bc.text_byte);
        step     = cur & i_ctl.in_range & ~i_ctl.end_anchor & byte_hit;
        // a starred element stays put on a hit, a plain one moves on
        nxt      = (step & i_ctl.star) | i_link.adv | i_link.nxt_sk_b;

        o_link.adv      = step & ~i_ctl.star;
        o_link.cur_sk_a = cur & i_ctl.star;
        o_link.cur_sk_b = i_link.cur_sk_a;
        o_link.nxt_sk_a = nxt & i_ctl.star;
        o_link.nxt_sk_b = i_link.nxt_sk_a;

        o_stat.acc_cur  = cur & i_ctl.at_len;
        o_stat.acc_nxt  = nxt & i_ctl.at_len;
        o_stat.end_hit  = cur & i_ctl.end_anchor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= i_ctl.is_zero;
        end else if (i_bc.rearm) begin
            r_live <= i_ctl.is_zero;
        end else if (i_bc.load) begin
            r_live <= nxt;
        end
    end

endmodule

FILE: design/regex_star_dot_anchor_matcher_top.sv
// ----------------------------------------------------------------------------
// regex_star_dot_anchor_matcher_top: streaming pattern matcher
// Pattern with '^', '$', '.' and 'c*' matched over text bytes by a row of cells.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_kind, i_text_byte | item in
//  out     | o_out_valid, i_out_stall, o_matched       | item out
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | write
//
//  One item per cycle while not stalled; each item settles through the single
//  ripple of live positions along the cell row (two passes, closure and step).
//  An end item's result appears in the output register in the next cycle.
//  Reset (synchronous) leaves an empty pattern and position 0 live.
//  Input stalls only while a result waits and the output is stalled.
// ----------------------------------------------------------------------------
module regex_star_dot_anchor_matcher_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [7:0]                      i_text_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_matched,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsdam_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rsdam_pkg::WORD_W-1:0]    i_cfg_data
);
    import rsdam_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_pat [MAX_PATTERN_BYTES];
    logic             r_at_start;
    logic             r_match;
    logic             r_out_valid;
    logic             r_out_matched;

    logic [LEN_W-1:0] len_c;
    logic             anch;
    logic             cfg_wr;
    logic             in_acc;
    logic             byte_acc;
    logic             end_acc;
    logic             n_match;
    t_bcast           bc;
    t_cell_ctl        ctl   [NUM_POS];
    t_link            links [NUM_POS+1];
    t_cell_stat       stat  [NUM_POS];
    logic [NUM_POS-1:0] acc_cur_v;
    logic [NUM_POS-1:0] acc_nxt_v;
    logic [NUM_POS-1:0] end_hit_v;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
                r_pat[j] <= '0;
            end
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_PATTERN_LENGTH) begin
                r_len <= i_cfg_data[LEN_W-1:0];
            end
            for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
                if (i_cfg_index == CFG_IDX_W'(CFG_PATTERN_WORD0 + (j >> 3))) begin
                    r_pat[j] <= i_cfg_data[(j & 7)*8 +: 8];
                end
            end
        end
    end

    assign len_c = (r_len > LEN_W'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES) : r_len;
    assign anch  = (len_c != '0) && (r_pat[0] == CH_CARET);

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign byte_acc   = in_acc & (i_kind == KIND_BYTE);
    assign end_acc    = in_acc & (i_kind == KIND_END);

    always_comb begin
        bc.at_start  = r_at_start;
        bc.anch      = anch;
        bc.text_byte = i_text_byte;
        bc.load      = byte_acc;
        bc.rearm     = end_acc;
    end

    assign links[0] = '0;

    for (genvar i = 0; i < NUM_POS; i++) begin : g_cell
        logic [7:0] pb;
        logic       nxt_star;

        if (i < MAX_PATTERN_BYTES) begin : g_byte
            assign pb = r_pat[i];
        end else begin : g_nobyte
            assign pb = '0;
        end

        if (i + 1 < MAX_PATTERN_BYTES) begin : g_star
            assign nxt_star = (r_pat[i+1] == CH_STAR);
        end else begin : g_nostar
            assign nxt_star = 1'b0;
        end

        always_comb begin
            ctl[i].pat_byte   = pb;
            ctl[i].star       = (LEN_W'(i + 1) < len_c) & nxt_star;
            ctl[i].in_range   = LEN_W'(i) < len_c;
            ctl[i].in_mask    = LEN_W'(i) <= len_c;
            ctl[i].at_len     = LEN_W'(i) == len_c;
            ctl[i].end_anchor = (len_c != '0) & (LEN_W'(i + 1) == len_c) & (pb == CH_DOLLAR);
            ctl[i].start      = (i == 1) ? anch : ((i == 0) ? ~anch : 1'b0);
            ctl[i].is_zero    = (i == 0);
        end

        rsdam_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[i]),
            .i_bc    (bc),
            .i_link  (links[i]),
            .o_link  (links[i+1]),
            .o_stat  (stat[i])
        );

        assign acc_cur_v[i] = stat[i].acc_cur;
        assign acc_nxt_v[i] = stat[i].acc_nxt;
        assign end_hit_v[i] = stat[i].end_hit;
    end

    // the last link only feeds positions beyond the row
    logic unused_link;
    assign unused_link = ^links[NUM_POS];

    assign n_match = r_match | (|acc_cur_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (byte_acc) begin
                r_at_start <= 1'b0;
                r_match    <= n_match | (|acc_nxt_v);
            end else if (end_acc) begin
                r_at_start <= 1'b1;
                r_match    <= 1'b0;
            end
            if (end_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_acc) begin
            r_out_matched <= n_match | (|end_hit_v);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_out_matched;

endmodule

FILE: bench/tb_regex_star_dot_anchor_matcher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_regex_star_dot_anchor_matcher_top: self-checking bench for the matcher
// Loads patterns through the register port, streams text bytes and end items,
// and predicts every verdict from a bit-parallel model of the live positions.
// ----------------------------------------------------------------------------
module tb_regex_star_dot_anchor_matcher_top;
    import rsdam_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int RAND_ITEMS    = 1300;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
    } t_text_item;

    // keeps its own copy of the pattern registers and the live position set
    class t_verdict_board;
        logic [LEN_W-1:0]  len_reg;
        logic [WORD_W-1:0] words [4];
        logic [32:0]       live;
        logic              seen;
        logic              at_start;
        logic              expected_verdicts [$];
        int                mismatches;
        int                verdict_no;

        function new();
            len_reg    = '0;
            for (int k = 0; k < 4; k++) words[k] = '0;
            live       = 33'd1;
            seen       = 1'b0;
            at_start   = 1'b1;
            mismatches = 0;
            verdict_no = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            int w;
            w = int'(idx) - int'(CFG_PATTERN_WORD0);
            if (idx == CFG_PATTERN_LENGTH) len_reg = data[LEN_W-1:0];
            else if (w >= 0 && w < 4) words[w] = data;
        endfunction

        function int eff_len();
            return (int'(len_reg) > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(len_reg);
        endfunction

        function logic [7:0] pat_at(int k);
            return words[k / 8][(k % 8) * 8 +: 8];
        endfunction

        function bit starred(int i, int n);
            return (i + 1 < n) && (pat_at(i + 1) == CH_STAR);
        endfunction

        function bit end_anchor(int i, int n);
            return (n > 0) && (i == n - 1) && (pat_at(i) == CH_DOLLAR);
        endfunction

        function logic [32:0] span_mask(int n);
            logic [32:0] m;
            m = '0;
            for (int i = 0; i <= n; i++) m[i] = 1'b1;
            return m;
        endfunction

        // a live 'c*' also makes the element after it live
        function logic [32:0] close_over_stars(logic [32:0] s, int n);
            for (int i = 0; i < n; i++)
                if (s[i] && starred(i, n)) s[i + 2] = 1'b1;
            return s & span_mask(n);
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function void take_item(t_text_item it);
            int          n;
            bit          anch;
            logic [32:0] first_pos, cur, nxt;
            logic [7:0]  p;
            logic        hit;
            n         = eff_len();
            anch      = (n > 0) && (pat_at(0) == CH_CARET);
            first_pos = '0;
            first_pos[anch ? 1 : 0] = 1'b1;
            cur = at_start ? first_pos : (live & span_mask(n));
            if (!anch) cur |= first_pos;
            cur = close_over_stars(cur, n);
            if (cur[n]) seen = 1'b1;
            if (it.kind == KIND_BYTE) begin
                nxt = '0;
                for (int i = 0; i < n; i++) begin
                    p = pat_at(i);
                    if (cur[i] && !end_anchor(i, n) && (p == CH_DOT || p == it.text_byte)) begin
                        if (starred(i, n)) nxt[i] = 1'b1;
                        else nxt[i + 1] = 1'b1;
                    end
                end
                nxt = close_over_stars(nxt, n);
                if (nxt[n]) seen = 1'b1;
                live     = nxt;
                at_start = 1'b0;
            end else begin
                hit = seen || (n > 0 && end_anchor(n - 1, n) && cur[n - 1]);
                expected_verdicts.push_back(hit);
                live     = 33'd1;
                seen     = 1'b0;
                at_start = 1'b1;
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            mismatches++;
        endtask

        task check_verdict(logic got);
            logic want;
            verdict_no++;
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict %0d: matched=%0d with none due",
                                          verdict_no, got));
            end else begin
                want = expected_verdicts.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("verdict %0d: matched=%0d, predicted %0d",
                                              verdict_no, got, want));
            end
        endtask

        task check_drained();
            if (expected_verdicts.size() != 0)
                report_mismatch($sformatf("%0d verdicts never arrived",
                                          expected_verdicts.size()));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_kind      = KIND_BYTE;
    logic [7:0]           i_text_byte = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_matched;
    logic                 o_cfg_ready;

    regex_star_dot_anchor_matcher_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_text_byte (i_text_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_matched   (o_matched),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_verdict_board board;
    logic [7:0]   pat_bytes [32];
    int           sent          = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_req      = 0;
    int           hold_ack      = 0;
    int           hold_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) board.set_reg(i_cfg_index, i_cfg_data);
        if (i_rst_n && i_in_valid && !o_in_stall) board.take_item('{i_kind, i_text_byte});
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_verdict(o_matched);
    end

    task automatic send_item(input logic kind, input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_text_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_item(KIND_BYTE, s[k]);
    endtask

    // let every verdict come out before touching the registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_pattern(input logic [LEN_W-1:0] raw_len);
        logic [WORD_W-1:0] w;
        write_reg(CFG_PATTERN_LENGTH, WORD_W'(raw_len));
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 8; j++) w[j*8 +: 8] = pat_bytes[k*8 + j];
            write_reg(CFG_PATTERN_WORD0 + CFG_IDX_W'(k), w);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // bytes past the string are garbage the block must ignore
    function automatic void set_pattern(input string s);
        for (int k = 0; k < 32; k++) pat_bytes[k] = (k < s.len()) ? s[k] : 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_pat_char();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 8'h61 + 8'($urandom_range(2));
        if (r < 70) return CH_DOT;
        if (r < 90) return CH_STAR;
        if (r < 95) return CH_DOLLAR;
        return CH_CARET;
    endfunction

    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 8'h61 + 8'($urandom_range(2));
        if (r < 75) return CH_STAR;
        if (r < 78) return CH_DOLLAR;
        if (r < 80) return CH_CARET;
        return 8'($urandom_range(255));
    endfunction

    task automatic make_pattern(output logic [LEN_W-1:0] raw_len, output int n);
        int r;
        r = $urandom_range(99);
        if (r < 60) n = $urandom_range(0, 6);
        else if (r < 85) n = $urandom_range(7, 16);
        else n = $urandom_range(17, 32);
        raw_len = LEN_W'(n);
        if ($urandom_range(19) == 0) begin
            n       = MAX_PATTERN_BYTES;
            raw_len = LEN_W'($urandom_range(33, 63));
        end
        for (int k = 0; k < 32; k++) pat_bytes[k] = (k < n) ? pick_pat_char() : 8'($urandom);
        if (n > 0 && $urandom_range(99) < 35) pat_bytes[0] = CH_CARET;
        if (n > 1 && $urandom_range(99) < 35) pat_bytes[n-1] = CH_DOLLAR;
    endtask

    // text built by walking the pattern, then roughened; sometimes pure noise
    task automatic run_text(input int n, input bit finish);
        int         i, reps;
        bit         star;
        logic [7:0] c;
        logic [7:0] t [$];
        repeat ($urandom_range(0, 2)) t.push_back(pick_text_char());
        i = (n > 0 && pat_bytes[0] == CH_CARET) ? 1 : 0;
        while (i < n && !(i == n - 1 && pat_bytes[i] == CH_DOLLAR)) begin
            c    = pat_bytes[i];
            star = (i + 1 < n) && (pat_bytes[i+1] == CH_STAR);
            reps = star ? $urandom_range(0, 3) : 1;
            repeat (reps) t.push_back((c == CH_DOT) ? pick_text_char() : c);
            i += star ? 2 : 1;
        end
        repeat ($urandom_range(0, 2)) t.push_back(pick_text_char());
        if (t.size() > 0 && $urandom_range(99) < 30)
            t[$urandom_range(t.size() - 1)] = pick_text_char();
        if ($urandom_range(9) == 0) begin
            t.delete();
            repeat ($urandom_range(0, 6)) t.push_back(8'($urandom_range(255)));
        end
        foreach (t[k]) send_item(KIND_BYTE, t[k]);
        if (finish) send_item(KIND_END, 8'($urandom_range(255)));
    endtask

    initial begin
        logic [LEN_W-1:0] raw_len;
        int               n, phase_goal;
        bit               pressure_done;
        board         = new();
        pressure_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern with all-ones words: the empty text matches
        for (int k = 0; k < 32; k++) pat_bytes[k] = 8'hFF;
        load_pattern(0);
        send_item(KIND_END, 8'h00);
        // lone caret matches anything
        wait_idle();
        set_pattern("^");
        load_pattern(1);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_END, 8'hFF);
        // both anchors, dot and star
        wait_idle();
        set_pattern("^a.*c$");
        load_pattern(6);
        send_text("a");
        send_item(KIND_BYTE, 8'h00);
        send_text("c");
        send_item(KIND_END, 8'h00);
        // leading star and a dollar before the end are plain literals
        wait_idle();
        set_pattern("*a$b");
        load_pattern(4);
        send_text("x*a$b");
        send_item(KIND_END, 8'h00);
        // starred element taken zero times
        wait_idle();
        set_pattern("ab*c");
        load_pattern(4);
        send_text("ac");
        send_item(KIND_END, 8'h00);
        // oversized length clamps to the full 32 bytes
        wait_idle();
        for (int k = 0; k < 32; k++) pat_bytes[k] = k[0] ? CH_STAR : 8'hFF;
        load_pattern(63);
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_END, 8'h00);
        // pattern swapped in the middle of a text
        wait_idle();
        set_pattern("ab");
        load_pattern(2);
        send_text("a");
        wait_idle();
        set_pattern("bc");
        load_pattern(2);
        send_text("c");
        send_item(KIND_END, 8'h00);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 45 : 0;
            recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 9 : 0;
            phase_goal    = sent + RAND_ITEMS / 3;
            while (sent < phase_goal) begin
                wait_idle();
                make_pattern(raw_len, n);
                load_pattern(raw_len);
                if (ph == 0 && !pressure_done) begin
                    // output held off for a long time: results back up into the input
                    pressure_done = 1'b1;
                    hold_req++;
                    repeat (24) begin
                        send_item(KIND_BYTE, pick_text_char());
                        send_item(KIND_END, 8'($urandom_range(255)));
                    end
                end
                repeat ($urandom_range(3, 7)) run_text(n, 1'b1);
                // now and then leave a text open across the next pattern load
                if ($urandom_range(9) == 0) run_text(n, 1'b0);
            end
        end
        send_item(KIND_END, 8'h00);

        wait_idle();
        board.check_drained();
        if (board.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
